FILE: rtl/plc_pkg.sv
// Shared constants and types for the piecewise-linear calibration block.
// Holds field widths, item kinds, register offsets and the flag value.
// No dependencies.
package plc_pkg;

	localparam int COORD_W   = 24;
	localparam int QUERY_W   = 32;
	localparam int RESULT_W  = 32;
	localparam int MODE_W    = 2;
	localparam int PIDX_W    = 4;
	localparam int COUNT_W   = 5;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int S_TDATA_W = 88;
	localparam int DIV_STEPS = COORD_W;

	localparam int DEFAULT_MAX_POINTS = 16;

	// Item kinds carried on the input tuser.
	localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FWD  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_INV  = 2'd2;

	// Register index decoded from paddr[2].
	localparam logic REG_POINTS_IN_USE = 1'b0;

	localparam logic signed [RESULT_W-1:0] FLAG_VALUE = 32'sh7FFF_FFFF;

	typedef logic signed [COORD_W-1:0] coord_t;

	// One stored table entry: calibrated value above raw coordinate.
	typedef struct packed {
		coord_t value;
		coord_t raw;
	} point_t;

endpackage

FILE: rtl/piecewise_linear_calibration.sv
// Piecewise-linear calibration table with forward and inverse conversion.
// A load word writes the table entry and still returns a result. A conversion reads the first
// and last segments, then searches: a binary search for raw to calibrated, a linear scan for the
// inverse, one table read per probe; an inner point then runs the 24-step serial divider.
// One word is in work at a time; a new word is taken while the last result waits.
// arst_n clears control and points_in_use; the point table holds no reset value.
module piecewise_linear_calibration
	import plc_pkg::*;
#(
	parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input stream.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [3:0] point_index, [27:4] point_raw, [51:28] point_value, [83:52] query, [84] clamp
	input  logic [S_TDATA_W-1:0]  s_tdata,
	// [1:0] mode
	input  logic [MODE_W-1:0]     s_tuser,
	// Result stream.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [31:0] result
	output logic [RESULT_W-1:0]   m_tdata,
	// [0] out_of_range
	output logic                  m_tuser,
	// Configuration port.
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [PDATA_W-1:0]    pwdata,
	output logic [PDATA_W-1:0]    prdata,
	output logic                  pready
);

	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int SW = 4;

	localparam logic [SW-1:0] ST_IDLE  = 4'd0;
	localparam logic [SW-1:0] ST_FIRST = 4'd1;
	localparam logic [SW-1:0] ST_LAST  = 4'd2;
	localparam logic [SW-1:0] ST_FWD_B = 4'd3;
	localparam logic [SW-1:0] ST_FWD_E = 4'd4;
	localparam logic [SW-1:0] ST_FWD_M = 4'd5;
	localparam logic [SW-1:0] ST_INV   = 4'd6;
	localparam logic [SW-1:0] ST_MUL   = 4'd7;
	localparam logic [SW-1:0] ST_DIV   = 4'd8;
	localparam logic [SW-1:0] ST_RND   = 4'd9;
	localparam logic [SW-1:0] ST_DONE  = 4'd10;

	// Input fields.
	logic [PIDX_W-1:0]         in_index;
	coord_t                    in_raw;
	coord_t                    in_value;
	logic signed [QUERY_W-1:0] in_query;
	logic                      in_clamp;

	assign in_index = s_tdata[3:0];
	assign in_raw   = s_tdata[27:4];
	assign in_value = s_tdata[51:28];
	assign in_query = s_tdata[83:52];
	assign in_clamp = s_tdata[84];

	// Control and item state.
	logic [SW-1:0]             state_q, state_d;
	logic [COUNT_W-1:0]        points_q;
	logic                      m_tvalid_q;
	logic [MODE_W-1:0]         mode_q;
	logic signed [QUERY_W-1:0] q_q;
	logic                      clamp_q;
	logic [IW-1:0]             lastseg_q;
	logic [IW-1:0]             beg_q, end_q, mid_q, inv_i_q;
	coord_t                    first_lx_q, first_ly_q, last_rx_q, last_ry_q;

	// Shared multiply and divide unit.
	logic [COORD_W-1:0]        mul_a_q, mul_b_q, den_q;
	logic                      neg_q;
	coord_t                    base_q;
	logic [COORD_W-1:0]        rem_q, low_q;
	logic [COUNT_W-1:0]        cnt_q;

	logic signed [RESULT_W-1:0] pend_res_q;
	logic                       pend_flag_q;
	logic [RESULT_W-1:0]        m_tdata_q;
	logic                       m_tuser_q;

	// Point table and its two registered read ports.
	point_t                    pts_q [MAX_POINTS];
	point_t                    rd0_q, rd1_q;
	logic [IW-1:0]             rd_addr;
	logic [IW-1:0]             rd_addr1;
	logic                      load_we;
	logic [IW-1:0]             wr_addr;

	// Configuration.
	logic                      cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_POINTS_IN_USE);
	assign prdata = (paddr[2] == REG_POINTS_IN_USE) ? PDATA_W'(points_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_q <= '0;
		end else if (cfg_we) begin
			points_q <= pwdata[COUNT_W-1:0];
		end
	end

	// Points in use, limited to the table depth.
	logic [CW-1:0] n_c;
	logic          few_c;

	assign n_c   = (int'(points_q) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(points_q);
	assign few_c = (n_c < CW'(2));

	assign s_tready = (state_q == ST_IDLE);
	assign wr_addr  = IW'(in_index);
	assign load_we  = s_tvalid && s_tready && (s_tuser == MODE_LOAD) &&
		(int'(in_index) < MAX_POINTS);

	always_ff @(posedge clk) begin
		if (load_we) begin
			pts_q[wr_addr] <= '{value: in_value, raw: in_raw};
		end
		rd0_q <= pts_q[rd_addr];
		rd1_q <= pts_q[rd_addr1];
	end

	// Segment from the last read, oriented so that left has the smaller raw value.
	coord_t seg_lx, seg_ly, seg_rx, seg_ry;
	logic   seg_swap;

	assign seg_swap = (rd1_q.raw < rd0_q.raw);
	assign seg_lx   = seg_swap ? rd1_q.raw   : rd0_q.raw;
	assign seg_ly   = seg_swap ? rd1_q.value : rd0_q.value;
	assign seg_rx   = seg_swap ? rd0_q.raw   : rd1_q.raw;
	assign seg_ry   = seg_swap ? rd0_q.value : rd1_q.value;

	logic signed [QUERY_W-1:0] lx32, ly32, rx32, ry32;
	logic signed [QUERY_W-1:0] first_lx32, first_ly32, last_rx32, last_ry32;

	assign lx32       = QUERY_W'(seg_lx);
	assign ly32       = QUERY_W'(seg_ly);
	assign rx32       = QUERY_W'(seg_rx);
	assign ry32       = QUERY_W'(seg_ry);
	assign first_lx32 = QUERY_W'(first_lx_q);
	assign first_ly32 = QUERY_W'(first_ly_q);
	assign last_rx32  = QUERY_W'(last_rx_q);
	assign last_ry32  = QUERY_W'(last_ry_q);

	logic in_x, in_y, below_x, above_x;

	assign below_x = (q_q < lx32);
	assign above_x = (q_q > rx32);
	assign in_x    = !below_x && !above_x;
	assign in_y    = (q_q >= ly32) && (q_q <= ry32);

	// Binary search midpoint and span.
	logic [IW-1:0] span_c, mid_c;

	assign span_c = end_q - beg_q;
	assign mid_c  = beg_q + (span_c >> 1);

	always_comb begin
		case (state_q)
			ST_FIRST: rd_addr = lastseg_q;
			ST_FWD_B: rd_addr = end_q;
			ST_FWD_E: rd_addr = mid_c;
			ST_FWD_M: rd_addr = above_x ? mid_q : beg_q;
			ST_INV:   rd_addr = inv_i_q + IW'(1);
			default:  rd_addr = '0;
		endcase
	end

	assign rd_addr1 = rd_addr + IW'(1);

	// Operand setup for a hit segment; the endpoint cases need no division.
	logic signed [COORD_W:0]   dy_c, dx_c;
	logic [COORD_W-1:0]        dy_mag;
	logic                      hit_exact;
	logic signed [QUERY_W-1:0] hit_value;
	logic [COORD_W-1:0]        set_a, set_b, set_den;
	logic                      set_neg;
	coord_t                    set_base;

	assign dy_c   = {seg_ry[COORD_W-1], seg_ry} - {seg_ly[COORD_W-1], seg_ly};
	assign dx_c   = {seg_rx[COORD_W-1], seg_rx} - {seg_lx[COORD_W-1], seg_lx};
	assign dy_mag = dy_c[COORD_W] ? COORD_W'(-dy_c) : dy_c[COORD_W-1:0];

	always_comb begin
		hit_exact = 1'b0;
		hit_value = '0;
		if (mode_q == MODE_FWD) begin
			set_a    = COORD_W'(q_q - lx32);
			set_b    = dy_mag;
			set_den  = dx_c[COORD_W-1:0];
			set_neg  = dy_c[COORD_W];
			set_base = seg_ly;
			if (q_q == lx32) begin
				hit_exact = 1'b1;
				hit_value = ly32;
			end else if (q_q == rx32) begin
				hit_exact = 1'b1;
				hit_value = ry32;
			end
		end else begin
			set_a    = COORD_W'(q_q - ly32);
			set_b    = dx_c[COORD_W-1:0];
			set_den  = dy_c[COORD_W-1:0];
			set_neg  = 1'b0;
			set_base = seg_lx;
			if (q_q == ly32) begin
				hit_exact = 1'b1;
				hit_value = lx32;
			end else if (q_q == ry32) begin
				hit_exact = 1'b1;
				hit_value = rx32;
			end
		end
	end

	// One restoring divide step per cycle.
	logic [COORD_W:0]   div_t;
	logic               div_ge;
	logic               rnd_up;
	logic [COORD_W:0]   quot_c;
	logic signed [RESULT_W-1:0] rnd_res;

	assign div_t   = {rem_q, low_q[COORD_W-1]};
	assign div_ge  = (div_t >= {1'b0, den_q});
	assign rnd_up  = ({rem_q, 1'b0} >= {1'b0, den_q});
	assign quot_c  = {1'b0, low_q} + (COORD_W+1)'(rnd_up);
	assign rnd_res = RESULT_W'(base_q) +
		(neg_q ? -RESULT_W'(quot_c) : RESULT_W'(quot_c));

	// Sequencer.
	logic                       hit, fin, fin_flag, mul_go, out_load;
	logic signed [RESULT_W-1:0] fin_res;

	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	always_comb begin
		state_d  = state_q;
		hit      = 1'b0;
		fin      = 1'b0;
		fin_flag = 1'b0;
		fin_res  = '0;
		mul_go   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if ((s_tuser == MODE_FWD) || (s_tuser == MODE_INV)) begin
						if (few_c) begin
							fin      = 1'b1;
							fin_flag = 1'b1;
						end else begin
							state_d = ST_FIRST;
						end
					end else begin
						fin = 1'b1;
					end
				end
			end
			ST_FIRST: state_d = ST_LAST;
			ST_LAST: begin
				if (mode_q == MODE_FWD) begin
					if (q_q < first_lx32) begin
						fin      = 1'b1;
						fin_flag = !clamp_q;
						fin_res  = first_ly32;
					end else if (above_x) begin
						fin      = 1'b1;
						fin_flag = !clamp_q;
						fin_res  = ry32;
					end else begin
						state_d = ST_FWD_B;
					end
				end else begin
					state_d = ST_INV;
				end
			end
			ST_FWD_B: begin
				if (in_x) begin
					hit = 1'b1;
				end else begin
					state_d = ST_FWD_E;
				end
			end
			ST_FWD_E: begin
				if (in_x) begin
					hit = 1'b1;
				end else if (span_c <= IW'(1)) begin
					fin      = 1'b1;
					fin_flag = 1'b1;
				end else begin
					state_d = ST_FWD_M;
				end
			end
			ST_FWD_M: begin
				if (below_x || above_x) begin
					state_d = ST_FWD_B;
				end else begin
					hit = 1'b1;
				end
			end
			ST_INV: begin
				if (in_y) begin
					hit = 1'b1;
				end else if (inv_i_q == lastseg_q) begin
					fin = 1'b1;
					if (clamp_q && (q_q < first_ly32)) begin
						fin_res = first_lx32;
					end else if (clamp_q && (q_q > last_ry32)) begin
						fin_res = last_rx32;
					end else begin
						fin_flag = 1'b1;
					end
				end
			end
			ST_MUL: state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == COUNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_RND;
				end
			end
			ST_RND: begin
				fin     = 1'b1;
				fin_res = rnd_res;
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (hit) begin
			if (hit_exact) begin
				fin     = 1'b1;
				fin_res = hit_value;
			end else begin
				mul_go  = 1'b1;
				state_d = ST_MUL;
			end
		end
		if (fin) begin
			state_d = ST_DONE;
			if (fin_flag) begin
				fin_res = FLAG_VALUE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_q    <= s_tuser;
			q_q       <= in_query;
			clamp_q   <= in_clamp;
			lastseg_q <= IW'(n_c - CW'(2));
		end
		case (state_q)
			ST_FIRST: begin
				first_lx_q <= seg_lx;
				first_ly_q <= seg_ly;
			end
			ST_LAST: begin
				last_rx_q <= seg_rx;
				last_ry_q <= seg_ry;
				beg_q     <= '0;
				end_q     <= lastseg_q;
				inv_i_q   <= '0;
			end
			ST_FWD_E: mid_q <= mid_c;
			ST_FWD_M: begin
				if (below_x) begin
					end_q <= mid_q;
				end else if (above_x) begin
					beg_q <= mid_q;
				end
			end
			ST_INV: inv_i_q <= inv_i_q + IW'(1);
			ST_MUL: begin
				{rem_q, low_q} <= mul_a_q * mul_b_q;
				cnt_q          <= '0;
			end
			ST_DIV: begin
				rem_q <= div_ge ? COORD_W'(div_t - {1'b0, den_q}) : div_t[COORD_W-1:0];
				low_q <= {low_q[COORD_W-2:0], div_ge};
				cnt_q <= cnt_q + COUNT_W'(1);
			end
			default: ;
		endcase
		if (mul_go) begin
			mul_a_q <= set_a;
			mul_b_q <= set_b;
			den_q   <= set_den;
			neg_q   <= set_neg;
			base_q  <= set_base;
		end
		if (fin) begin
			pend_res_q  <= fin_res;
			pend_flag_q <= fin_flag;
		end
		if (out_load) begin
			m_tdata_q <= pend_res_q;
			m_tuser_q <= pend_flag_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
